// ===== rtl/core/fcps_pkg.sv =====
// ----------------------------------------------------------------------------
// fcps_pkg
// Shared types and constants for the fan curve PWM selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcps_pkg;

  localparam int RULE_REGS  = 4;
  localparam int RULE_W     = 28;
  localparam int BOUND_W    = 10;
  localparam int SPEED_W    = 7;
  localparam int DUTY_W     = 8;
  localparam int IDX_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = DUTY_W + SPEED_W;

  localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

  // floor(x / 100) == (x * 5243) >> 19 for every x below 25600
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP = 13'd5243;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE0         = 3'd2;

  localparam logic [DUTY_W-1:0]  FULL_SPEED_RST    = 8'd255;
  localparam logic [SPEED_W-1:0] DEFAULT_SPEED_RST = 7'd0;

  typedef struct packed {
    logic               valid;
    logic [SPEED_W-1:0] speed;
    logic [BOUND_W-1:0] rng_end;
    logic [BOUND_W-1:0] rng_start;
  } rule_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  full_speed;
    logic [SPEED_W-1:0] default_speed;
  } cfg_t;

  typedef struct packed {
    logic               kick;
    logic               matched;
    logic [IDX_W-1:0]   idx;
    logic [SPEED_W-1:0] speed;
  } match_t;

  typedef struct packed {
    logic              kick;
    logic              matched;
    logic [IDX_W-1:0]  idx;
    logic [PROD_W-1:0] prod;
  } scale_t;

endpackage

// ===== rtl/core/fan_curve_pwm_select.sv =====
// ----------------------------------------------------------------------------
// fan_curve_pwm_select
// Fan curve PWM selector with start kick: sample -> rule match -> duty.
//
//   channel  dir  signals                          payload
//   s_*      in   tvalid tready tdata              sensor_value
//   m_*      out  tvalid tready tdata tuser tlast  duty / kick matched rule_index
//   cfg_*    in   valid ready index data           register write
//
// One item accepted per cycle while no stage is stalled; an item emits one
// result, or two (kick then target) when the applied speed goes from zero to
// nonzero, and a kick holds off the next item at the output port. The first
// result passes four registers (input, match, product and output registers).
// Reset is synchronous, clears all valid flags and the applied speed and
// restores register defaults. Output stalls back up through the stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fan_curve_pwm_select #(
  parameter int RULE_SLOTS  = 4,
  parameter int SENSOR_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SENSOR_BITS+7)/8)*8-1:0]    s_tdata,   // sensor_value
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fcps_pkg::DUTY_W-1:0]         m_tdata,   // duty
  output logic [3:0]                          m_tuser,   // kick, matched, rule_index
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fcps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcps_pkg::RULE_W-1:0]         cfg_data
);

  localparam int NSLOT = (RULE_SLOTS < fcps_pkg::RULE_REGS) ? RULE_SLOTS : fcps_pkg::RULE_REGS;
  localparam int QUO_W = fcps_pkg::PROD_W + fcps_pkg::RECIP_W;

  fcps_pkg::cfg_t                 cfg;
  fcps_pkg::rule_t [NSLOT-1:0]    rules;

  logic                           in_valid;
  logic [SENSOR_BITS-1:0]         sample;
  logic                           match_ready;

  fcps_pkg::match_t               mres;
  logic                           mres_valid;
  logic                           scale_ready;

  fcps_pkg::scale_t               sres;
  logic                           sres_valid;
  logic                           out_ready_up;

  logic                           out_kick;
  logic                           out_matched;
  logic [fcps_pkg::IDX_W-1:0]     out_idx;
  logic [fcps_pkg::DUTY_W-1:0]    duty;
  logic [QUO_W-1:0]               quo_full;
  logic                           out_load;

  fcps_cfg #(
    .NSLOT (NSLOT)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .rules     (rules)
  );

  // input register
  assign s_tready = !in_valid || match_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sample <= s_tdata[SENSOR_BITS-1:0];
    end
  end

  fcps_match #(
    .NSLOT       (NSLOT),
    .SENSOR_BITS (SENSOR_BITS)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (match_ready),
    .sample    (sample),
    .cfg       (cfg),
    .rules     (rules),
    .out_valid (mres_valid),
    .out_ready (scale_ready),
    .res       (mres)
  );

  fcps_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (mres_valid),
    .in_ready   (scale_ready),
    .mres       (mres),
    .full_speed (cfg.full_speed),
    .out_valid  (sres_valid),
    .out_ready  (out_ready_up),
    .res        (sres)
  );

  // divide by 100 through reciprocal multiply
  assign quo_full = QUO_W'(sres.prod) * QUO_W'(fcps_pkg::RECIP);

  // output register; holds kick then target
  assign out_ready_up = !m_tvalid || (m_tready && !out_kick);
  assign out_load     = sres_valid && out_ready_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      out_kick <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
      out_kick <= sres.kick;
    end else if (m_tvalid && m_tready) begin
      if (out_kick) begin
        out_kick <= 1'b0;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      duty        <= quo_full[fcps_pkg::RECIP_SHIFT +: fcps_pkg::DUTY_W];
      out_matched <= sres.matched;
      out_idx     <= sres.idx;
    end
  end

  assign m_tdata = out_kick ? cfg.full_speed : duty;
  assign m_tuser = {out_idx, out_matched, out_kick};
  assign m_tlast = !out_kick;

endmodule

// ===== rtl/core/fcps_cfg.sv =====
// ----------------------------------------------------------------------------
// fcps_cfg
// Configuration register file: full speed, default speed and rule words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcps_cfg #(
  parameter int NSLOT = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fcps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcps_pkg::RULE_W-1:0]      cfg_data,
  output fcps_pkg::cfg_t                   cfg,
  output fcps_pkg::rule_t [NSLOT-1:0]      rules
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_speed    <= fcps_pkg::FULL_SPEED_RST;
      cfg.default_speed <= fcps_pkg::DEFAULT_SPEED_RST;
      rules             <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == fcps_pkg::CFG_FULL_SPEED) begin
        cfg.full_speed <= cfg_data[fcps_pkg::DUTY_W-1:0];
      end
      if (cfg_index == fcps_pkg::CFG_DEFAULT_SPEED) begin
        cfg.default_speed <= cfg_data[fcps_pkg::SPEED_W-1:0];
      end
      for (int i = 0; i < NSLOT; i++) begin
        if (cfg_index == fcps_pkg::CFG_IDX_W'(int'(fcps_pkg::CFG_RULE0) + i)) begin
          rules[i] <= cfg_data;
        end
      end
    end
  end

endmodule

// ===== rtl/core/fcps_match.sv =====
// ----------------------------------------------------------------------------
// fcps_match
// Rule match stage: picks the speed for a sample, clamps it, decides the
// start kick and tracks the applied speed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcps_match #(
  parameter int NSLOT       = 4,
  parameter int SENSOR_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SENSOR_BITS-1:0]        sample,
  input  fcps_pkg::cfg_t                cfg,
  input  fcps_pkg::rule_t [NSLOT-1:0]   rules,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fcps_pkg::match_t              res
);

  localparam int CMP_W = (SENSOR_BITS > fcps_pkg::BOUND_W) ? SENSOR_BITS : fcps_pkg::BOUND_W;

  logic [fcps_pkg::SPEED_W-1:0] current_speed;
  logic [fcps_pkg::SPEED_W-1:0] raw_speed;
  logic [fcps_pkg::SPEED_W-1:0] speed;
  logic                         matched;
  logic [fcps_pkg::IDX_W-1:0]   idx;
  logic                         alive;
  logic [CMP_W-1:0]             samp_x;
  logic                         load;

  assign samp_x = CMP_W'(sample);

  always_comb begin
    raw_speed = cfg.default_speed;
    matched   = 1'b0;
    idx       = '0;
    alive     = 1'b1;
    for (int i = 0; i < NSLOT; i++) begin
      alive = alive & rules[i].valid;
      if (alive && samp_x >= CMP_W'(rules[i].rng_start) &&
          samp_x <= CMP_W'(rules[i].rng_end)) begin
        raw_speed = rules[i].speed;
        matched   = 1'b1;
        idx       = fcps_pkg::IDX_W'(i);
      end
    end
    speed = (raw_speed > fcps_pkg::SPEED_MAX) ? fcps_pkg::SPEED_MAX : raw_speed;
  end

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      current_speed <= '0;
    end else if (load) begin
      out_valid     <= 1'b1;
      current_speed <= speed;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.speed   <= speed;
      res.matched <= matched;
      res.idx     <= idx;
      res.kick    <= (current_speed == '0) && (speed != '0);
    end
  end

endmodule

// ===== rtl/core/fcps_scale.sv =====
// ----------------------------------------------------------------------------
// fcps_scale
// Scale stage: full_speed * speed product, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcps_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fcps_pkg::match_t            mres,
  input  logic [fcps_pkg::DUTY_W-1:0] full_speed,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fcps_pkg::scale_t            res
);

  logic load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.prod    <= fcps_pkg::PROD_W'(full_speed) * fcps_pkg::PROD_W'(mres.speed);
      res.kick    <= mres.kick;
      res.matched <= mres.matched;
      res.idx     <= mres.idx;
    end
  end

endmodule

// ===== dv/fcps_checker.sv =====
// ----------------------------------------------------------------------------
// fcps_checker
// Watches the sample, result and register write channels of the fan curve
// PWM selector. Keeps its own copy of the rule table and the applied speed,
// predicts the kick and target results of every accepted sample, and compares
// each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcps_checker #(
  parameter int SDATA_W = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [SDATA_W-1:0]                s_tdata,   // sensor_value
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [fcps_pkg::DUTY_W-1:0]       m_tdata,   // duty
  input  logic [3:0]                        m_tuser,   // kick, matched, rule_index
  input  logic                              m_tlast,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [fcps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcps_pkg::RULE_W-1:0]       cfg_data,
  output int                                pending,
  output int                                errors
);

  typedef struct packed {
    logic [fcps_pkg::DUTY_W-1:0] duty;
    logic                        kick;
    logic                        matched;
    logic [fcps_pkg::IDX_W-1:0]  idx;
    logic                        last;
  } pwm_result_t;

  logic [fcps_pkg::DUTY_W-1:0]  full_speed;
  logic [fcps_pkg::SPEED_W-1:0] default_speed;
  logic [fcps_pkg::SPEED_W-1:0] applied_speed;
  fcps_pkg::rule_t              rule_tbl [fcps_pkg::RULE_REGS];
  pwm_result_t                  duty_q [$];

  function automatic void predict_fan_duty(input logic [fcps_pkg::BOUND_W-1:0] sample);
    logic [fcps_pkg::SPEED_W-1:0] speed;
    logic [fcps_pkg::PROD_W-1:0]  prod;
    logic                         matched;
    logic                         scanning;
    logic [fcps_pkg::IDX_W-1:0]   idx;
    pwm_result_t                  res;
    speed    = default_speed;
    matched  = 1'b0;
    idx      = '0;
    scanning = 1'b1;
    for (int i = 0; i < fcps_pkg::RULE_REGS; i++) begin
      if (scanning) begin
        if (!rule_tbl[i].valid) begin
          scanning = 1'b0;
        end else if (sample >= rule_tbl[i].rng_start &&
                     sample <= rule_tbl[i].rng_end) begin
          matched = 1'b1;
          idx     = fcps_pkg::IDX_W'(i);
          speed   = rule_tbl[i].speed;
        end
      end
    end
    if (speed > fcps_pkg::SPEED_MAX) begin
      speed = fcps_pkg::SPEED_MAX;
    end
    prod = full_speed * speed;
    if (applied_speed == '0 && speed != '0) begin
      res = '{duty: full_speed, kick: 1'b1, matched: matched, idx: idx, last: 1'b0};
      duty_q.push_back(res);
    end
    applied_speed = speed;
    res = '{duty: fcps_pkg::DUTY_W'(prod / fcps_pkg::SPEED_MAX), kick: 1'b0,
            matched: matched, idx: idx, last: 1'b1};
    duty_q.push_back(res);
  endfunction

  always @(posedge clk) begin
    pwm_result_t want;
    pwm_result_t got;
    if (rst) begin
      full_speed    = fcps_pkg::FULL_SPEED_RST;
      default_speed = fcps_pkg::DEFAULT_SPEED_RST;
      applied_speed = '0;
      for (int i = 0; i < fcps_pkg::RULE_REGS; i++) begin
        rule_tbl[i] = '0;
      end
      duty_q.delete();
      errors = 0;
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{duty: m_tdata, kick: m_tuser[0], matched: m_tuser[1], idx: m_tuser[3:2],
                last: m_tlast};
        if (duty_q.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: unexpected result duty=%0d kick=%b matched=%b idx=%0d last=%b",
                     $time, got.duty, got.kick, got.matched, got.idx, got.last);
          end
          errors++;
        end else begin
          want = duty_q.pop_front();
          if (got !== want) begin
            if (errors < 10) begin
              $display({"%0t: result mismatch duty=%0d/%0d kick=%b/%b matched=%b/%b ",
                        "idx=%0d/%0d last=%b/%b (exp/got)"},
                       $time, want.duty, got.duty, want.kick, got.kick, want.matched,
                       got.matched, want.idx, got.idx, want.last, got.last);
            end
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fcps_pkg::CFG_FULL_SPEED) begin
          full_speed = cfg_data[fcps_pkg::DUTY_W-1:0];
        end else if (cfg_index == fcps_pkg::CFG_DEFAULT_SPEED) begin
          default_speed = cfg_data[fcps_pkg::SPEED_W-1:0];
        end else if (cfg_index >= fcps_pkg::CFG_RULE0 &&
                     int'(cfg_index) < int'(fcps_pkg::CFG_RULE0) + fcps_pkg::RULE_REGS) begin
          rule_tbl[cfg_index - fcps_pkg::CFG_RULE0] = cfg_data;
        end
      end
      if (s_tvalid && s_tready) begin
        predict_fan_duty(s_tdata[fcps_pkg::BOUND_W-1:0]);
      end
      pending <= duty_q.size();
    end
  end

endmodule

// ===== dv/tb_fan_curve_pwm_select.sv =====
// ----------------------------------------------------------------------------
// tb_fan_curve_pwm_select
// Drives sensor samples and register writes into the fan curve PWM selector
// with random gaps on both sides; a directed part covers rule ordering, empty
// ranges, speed clamping and the start kick, then random rule tables follow.
// The checker scores the results; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fan_curve_pwm_select;

  localparam int SDATA_W      = 16;
  localparam int IDLE_PCT     = 36;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 240;
  localparam logic [fcps_pkg::CFG_IDX_W-1:0] CFG_RULE1  = fcps_pkg::CFG_RULE0 + 3'd1;
  localparam logic [fcps_pkg::CFG_IDX_W-1:0] CFG_RULE2  = fcps_pkg::CFG_RULE0 + 3'd2;
  localparam logic [fcps_pkg::CFG_IDX_W-1:0] CFG_RULE3  = fcps_pkg::CFG_RULE0 + 3'd3;
  localparam logic [fcps_pkg::CFG_IDX_W-1:0] CFG_SPARE0 = fcps_pkg::CFG_RULE0 + 3'd4;
  localparam logic [fcps_pkg::CFG_IDX_W-1:0] CFG_SPARE1 = fcps_pkg::CFG_RULE0 + 3'd5;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [SDATA_W-1:0]                s_tdata = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [fcps_pkg::DUTY_W-1:0]       m_tdata;
  logic [3:0]                        m_tuser;
  logic                              m_tlast;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [fcps_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [fcps_pkg::RULE_W-1:0]       cfg_data = '0;
  logic                              calm = 1'b0;
  logic [fcps_pkg::RULE_W-1:0]       rule_word [fcps_pkg::RULE_REGS];
  int                                pending;
  int                                errors;
  int                                cycles = 0;

  always #2 clk = ~clk;

  fan_curve_pwm_select u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fcps_checker #(.SDATA_W(SDATA_W)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // valid stays high until the caller lowers it
  task automatic write_reg(input logic [fcps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fcps_pkg::RULE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx >= fcps_pkg::CFG_RULE0 &&
        int'(idx) < int'(fcps_pkg::CFG_RULE0) + fcps_pkg::RULE_REGS) begin
      rule_word[idx - fcps_pkg::CFG_RULE0] = data;
    end
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_sample(input logic [fcps_pkg::BOUND_W-1:0] value);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= SDATA_W'(value);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [fcps_pkg::RULE_W-1:0] random_rule();
    fcps_pkg::rule_t w;
    w.rng_start = fcps_pkg::BOUND_W'($urandom_range(1023));
    if ($urandom_range(99) < 80) begin
      w.rng_end = fcps_pkg::BOUND_W'($urandom_range(int'(w.rng_start),
                                     (int'(w.rng_start) + 400 > 1023) ? 1023
                                     : int'(w.rng_start) + 400));
    end else begin
      w.rng_end = fcps_pkg::BOUND_W'($urandom_range(1023));
    end
    case ($urandom_range(19))
      0, 1, 2, 3, 4: w.speed = '0;
      5, 6:          w.speed = fcps_pkg::SPEED_W'($urandom_range(127, 101));
      default:       w.speed = fcps_pkg::SPEED_W'($urandom_range(100, 1));
    endcase
    w.valid = ($urandom_range(99) < 85);
    return w;
  endfunction

  function automatic logic [fcps_pkg::BOUND_W-1:0] pick_sample();
    fcps_pkg::rule_t w;
    w = rule_word[$urandom_range(fcps_pkg::RULE_REGS-1)];
    case ($urandom_range(19))
      14, 15: return fcps_pkg::BOUND_W'(int'(w.rng_start) + $urandom_range(2) - 1);
      16:     return fcps_pkg::BOUND_W'(int'(w.rng_end) + $urandom_range(2) - 1);
      17:     return '0;
      18:     return '1;
      default: return fcps_pkg::BOUND_W'($urandom_range(1023));
    endcase
  endfunction

  task automatic random_config();
    logic [fcps_pkg::RULE_W-1:0] data;
    data = fcps_pkg::RULE_W'($urandom);
    case ($urandom_range(4))
      0:       data[fcps_pkg::DUTY_W-1:0] = '0;
      1:       data[fcps_pkg::DUTY_W-1:0] = '1;
      default: data[fcps_pkg::DUTY_W-1:0] = fcps_pkg::DUTY_W'($urandom);
    endcase
    write_reg(fcps_pkg::CFG_FULL_SPEED, data);
    data = fcps_pkg::RULE_W'($urandom);
    case ($urandom_range(9))
      0, 1, 2: data[fcps_pkg::SPEED_W-1:0] = '0;
      3:       data[fcps_pkg::SPEED_W-1:0] = fcps_pkg::SPEED_W'($urandom_range(127, 101));
      default: data[fcps_pkg::SPEED_W-1:0] = fcps_pkg::SPEED_W'($urandom_range(100));
    endcase
    write_reg(fcps_pkg::CFG_DEFAULT_SPEED, data);
    write_reg(fcps_pkg::CFG_RULE0, random_rule());
    write_reg(CFG_RULE1, random_rule());
    write_reg(CFG_RULE2, random_rule());
    write_reg(CFG_RULE3, random_rule());
    if ($urandom_range(1)) begin
      write_reg($urandom_range(1) ? CFG_SPARE0 : CFG_SPARE1, fcps_pkg::RULE_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < fcps_pkg::RULE_REGS; i++) begin
      rule_word[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset table: all rules invalid, default speed zero
    send_sample('0);
    send_sample('1);
    wait_drained();

    // overlapping rules, clamped speed, empty range, zero speed rule
    write_reg(fcps_pkg::CFG_FULL_SPEED, fcps_pkg::RULE_W'(255));
    write_reg(fcps_pkg::CFG_DEFAULT_SPEED, fcps_pkg::RULE_W'(0));
    write_reg(fcps_pkg::CFG_RULE0, {1'b1, 7'd40, 10'd300, 10'd0});
    write_reg(CFG_RULE1, {1'b1, 7'd127, 10'd600, 10'd200});
    write_reg(CFG_RULE2, {1'b1, 7'd50, 10'd700, 10'd800});
    write_reg(CFG_RULE3, {1'b1, 7'd0, 10'd1023, 10'd900});
    cfg_valid <= 1'b0;
    send_sample(10'd100);
    send_sample(10'd250);
    send_sample(10'd650);
    send_sample(10'd750);
    send_sample(10'd100);
    send_sample(10'd950);
    send_sample(10'd1023);
    send_sample(10'd0);
    send_sample(10'd300);
    send_sample(10'd301);
    send_sample(10'd600);
    send_sample(10'd601);
    send_sample(10'd899);
    send_sample(10'd900);
    wait_drained();

    // invalid rule cuts the table, zero full scale, default above 100
    write_reg(fcps_pkg::CFG_FULL_SPEED, {20'hFFFFF, 8'd0});
    write_reg(fcps_pkg::CFG_DEFAULT_SPEED, {21'h1FFFFF, 7'd101});
    write_reg(CFG_RULE1, {1'b0, 7'd90, 10'd600, 10'd200});
    write_reg(CFG_SPARE0, '1);
    write_reg(CFG_SPARE1, '1);
    cfg_valid <= 1'b0;
    send_sample(10'd250);
    send_sample(10'd500);
    send_sample(10'd1000);
    send_sample(10'd0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 3);
      random_config();
      repeat (PHASE_ITEMS) send_sample(pick_sample());
      wait_drained();
    end
    calm = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fcps_pkg.sv
rtl/core/fcps_cfg.sv
rtl/core/fcps_match.sv
rtl/core/fcps_scale.sv
rtl/core/fan_curve_pwm_select.sv
dv/fcps_checker.sv
dv/tb_fan_curve_pwm_select.sv
